>>> hdl/fmpsd_pkg.sv
// ============================================================================
// fmpsd_pkg
// Shared types, widths, register codes and the arctangent lookup for the
// FM phase-step pixel demodulator.
// ============================================================================
package fmpsd_pkg;

    localparam int BYTE_W     = 8;
    localparam int ANGLE_W    = 8;
    localparam int BIAS_W     = 10;
    localparam int BLANK_W    = 16;
    localparam int GAIN_W     = 13;
    localparam int ACC_W      = 14;
    localparam int POWER_W    = 9;
    localparam int CLIP_W     = 2;
    localparam int PIX_W      = 8;
    localparam int ACC_SHIFT  = 8;
    localparam int FRAC_SHIFT = 16;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int DEF_PIXELS_PER_ROW    = 224;
    localparam int DEF_SAMPLES_PER_PIXEL = 9;
    localparam int DEF_SAMPLE_STEP       = 3;

    localparam logic signed [BIAS_W-1:0]  BIAS_RESET  = '0;
    localparam logic signed [BLANK_W-1:0] BLANK_RESET = -16'sd1280;
    localparam logic [GAIN_W-1:0]         GAIN_RESET  = 13'd207;

    typedef enum logic [1:0] {
        REG_UNWRAP_BIAS = 2'd0,
        REG_BLANK_LEVEL = 2'd1,
        REG_PIXEL_GAIN  = 2'd2
    } cfg_reg_t;

    // One finished pixel as it leaves the accumulation stage
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic [POWER_W-1:0]      power;
        logic [CLIP_W-1:0]       clip;
        logic                    last;
    } pixel_rec_t;

    // round(atan(b/a) * 128 / pi), row a, column b, b <= a
    localparam logic [5:0] OCT_TAB [0:8][0:8] = '{
        '{6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd0, 6'd32, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd0, 6'd19, 6'd32, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd0, 6'd13, 6'd24, 6'd32, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd0, 6'd10, 6'd19, 6'd26, 6'd32, 6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd0, 6'd8,  6'd16, 6'd22, 6'd27, 6'd32, 6'd0,  6'd0,  6'd0},
        '{6'd0, 6'd7,  6'd13, 6'd19, 6'd24, 6'd28, 6'd32, 6'd0,  6'd0},
        '{6'd0, 6'd6,  6'd11, 6'd16, 6'd21, 6'd25, 6'd29, 6'd32, 6'd0},
        '{6'd0, 6'd5,  6'd10, 6'd15, 6'd19, 6'd23, 6'd26, 6'd29, 6'd32}
    };

    // Angle of a raw I/Q byte, 256 units per turn
    function automatic logic [ANGLE_W-1:0] angle_of(input logic [BYTE_W-1:0] b);
        logic [3:0]         ai;
        logic [3:0]         aq;
        logic [6:0]         t;
        logic [ANGLE_W-1:0] t8;
        logic [ANGLE_W-1:0] a;
        ai = b[7] ? 4'(~b[7:4] + 4'd1) : b[7:4];
        aq = b[3] ? 4'(~b[3:0] + 4'd1) : b[3:0];
        if (aq <= ai)
        begin
            t = {1'b0, OCT_TAB[ai][aq]};
        end
        else
        begin
            t = 7'd64 - {1'b0, OCT_TAB[aq][ai]};
        end
        t8 = {1'b0, t};
        if (!b[7])
        begin
            a = b[3] ? 8'(-t8) : t8;
        end
        else
        begin
            a = b[3] ? 8'(t8 - 8'd128) : 8'(8'd128 - t8);
        end
        if (ai == 4'd0 && aq == 4'd0)
        begin
            a = '0;
        end
        return a;
    endfunction

endpackage

>>> hdl/fm_phase_step_pixel_demod.sv
// ============================================================================
// fm_phase_step_pixel_demod
// FM phase-step demodulator turning raw 4-bit I/Q sample bytes into pixels.
// ============================================================================
// Input channel: one sample byte per item (I in the high nibble, Q in the
// low nibble) with line_start marking the reference sample of a row. Items
// are taken when in_valid is high and in_stall low.
// Output channel: one pixel per SAMPLES_PER_PIXEL samples (rounded down to
// whole sample steps) with its power sum, clip count and a last-of-row flag;
// a pixel is taken when out_valid is high and out_stall low. Line-start
// items and samples outside an active row give no pixel.
// Throughput: one item per clock, sustained while out_stall stays low. A
// pixel passes from the input register through the accumulation stage,
// the blank/scale stage and the gain multiply into the output register.
// Stall: a stalled pixel holds in the output register; the stages behind it
// keep filling and in_stall rises only once every stage holds an item.
// Reset: all rows idle, accumulators clear, registers at their defaults;
// the block waits for a line start. Configuration is written over APB.
// ============================================================================
module fm_phase_step_pixel_demod #(
    parameter int PIXELS_PER_ROW    = fmpsd_pkg::DEF_PIXELS_PER_ROW,
    parameter int SAMPLES_PER_PIXEL = fmpsd_pkg::DEF_SAMPLES_PER_PIXEL,
    parameter int SAMPLE_STEP       = fmpsd_pkg::DEF_SAMPLE_STEP
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fmpsd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fmpsd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fmpsd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fmpsd_pkg::BYTE_W-1:0]        sample_byte,
    input  logic                                line_start,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fmpsd_pkg::PIX_W-1:0]         pixel_value,
    output logic [fmpsd_pkg::POWER_W-1:0]       power_sum,
    output logic [fmpsd_pkg::CLIP_W-1:0]        clip_count,
    output logic                                row_last
);
    import fmpsd_pkg::*;

    logic signed [BIAS_W-1:0]  bias_reg;
    logic signed [BLANK_W-1:0] blank_reg;
    logic [GAIN_W-1:0]         gain_reg;

    logic       cfg_write;
    cfg_reg_t   cfg_sel;
    logic       pix_valid;
    pixel_rec_t pix;
    logic       pix_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg  <= BIAS_RESET;
            blank_reg <= BLANK_RESET;
            gain_reg  <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_UNWRAP_BIAS: bias_reg  <= pwdata[BIAS_W-1:0];
                REG_BLANK_LEVEL: blank_reg <= pwdata[BLANK_W-1:0];
                REG_PIXEL_GAIN:  gain_reg  <= pwdata[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_UNWRAP_BIAS: prdata = APB_DATA_W'(bias_reg);
            REG_BLANK_LEVEL: prdata = APB_DATA_W'(blank_reg);
            REG_PIXEL_GAIN:  prdata = APB_DATA_W'(gain_reg);
            default:         prdata = '0;
        endcase
    end

    fmpsd_track #(
        .PIXELS_PER_ROW    (PIXELS_PER_ROW),
        .SAMPLES_PER_PIXEL (SAMPLES_PER_PIXEL),
        .SAMPLE_STEP       (SAMPLE_STEP)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_byte (sample_byte),
        .line_start  (line_start),
        .unwrap_bias (bias_reg),
        .pix_valid   (pix_valid),
        .pix         (pix),
        .pix_ready   (pix_ready)
    );

    fmpsd_scale #(
        .SAMPLES_PER_PIXEL (SAMPLES_PER_PIXEL)
    ) u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .blank_level_q8 (blank_reg),
        .pixel_gain     (gain_reg),
        .pix_valid      (pix_valid),
        .pix            (pix),
        .pix_ready      (pix_ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel_value    (pixel_value),
        .power_sum      (power_sum),
        .clip_count     (clip_count),
        .row_last       (row_last)
    );

endmodule

>>> hdl/fmpsd_track.sv
// ============================================================================
// fmpsd_track
// Input register, row/pixel sequencing, phase-step unwrapping and the
// per-pixel accumulators. Emits one pixel record per completed pixel.
// ============================================================================
module fmpsd_track #(
    parameter int PIXELS_PER_ROW    = fmpsd_pkg::DEF_PIXELS_PER_ROW,
    parameter int SAMPLES_PER_PIXEL = fmpsd_pkg::DEF_SAMPLES_PER_PIXEL,
    parameter int SAMPLE_STEP       = fmpsd_pkg::DEF_SAMPLE_STEP
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [fmpsd_pkg::BYTE_W-1:0]            sample_byte,
    input  logic                                    line_start,
    input  logic signed [fmpsd_pkg::BIAS_W-1:0]     unwrap_bias,
    output logic                                    pix_valid,
    output fmpsd_pkg::pixel_rec_t                   pix,
    input  logic                                    pix_ready
);
    import fmpsd_pkg::*;

    localparam int STEPS_RAW = SAMPLES_PER_PIXEL / SAMPLE_STEP;
    localparam int STEPS     = (STEPS_RAW > 0) ? STEPS_RAW : 1;
    localparam int SPAN      = STEPS * SAMPLE_STEP;
    localparam int PH_W      = $clog2(SPAN + 1);
    localparam int SC_W      = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
    localparam int IDX_W     = $clog2(PIXELS_PER_ROW + 1);

    localparam logic [PH_W-1:0]  SPAN_C    = PH_W'(SPAN);
    localparam logic [SC_W-1:0]  STEP_LAST = SC_W'(SAMPLE_STEP - 1);
    localparam logic [IDX_W-1:0] ROW_LEN   = IDX_W'(PIXELS_PER_ROW);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // input stage
    logic                a_valid_reg;
    logic [BYTE_W-1:0]   a_byte_reg;
    logic                a_start_reg;

    // demodulator state
    logic [ANGLE_W-1:0]      prev_reg,   prev_next;
    logic signed [ACC_W-1:0] acc_reg,    acc_next;
    logic [PH_W-1:0]         phase_reg,  phase_next;
    logic [SC_W-1:0]         stepc_reg,  stepc_next;
    logic [IDX_W-1:0]        idx_reg,    idx_next;
    logic [POWER_W-1:0]      pwr_reg,    pwr_next;
    logic [CLIP_W-1:0]       clip_reg,   clip_next;
    logic                    active_reg, active_next;

    // pixel record stage
    logic       b_valid_reg, b_valid_next;
    pixel_rec_t b_rec_reg,   b_rec_next;
    logic       b_load;

    logic a_ready;
    logic b_ready;
    logic a_fire;

    logic [ANGLE_W-1:0]      angle;
    logic [ANGLE_W-1:0]      raw;
    logic signed [BIAS_W:0]  dstep;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic signed [7:0]       i_ext;
    logic signed [7:0]       q_ext;
    logic signed [7:0]       isq;
    logic signed [7:0]       qsq;
    logic [7:0]              sq_sum;
    logic [POWER_W:0]        pwr_sum;
    logic [POWER_W-1:0]      pwr_sat;
    logic                    clip_hit;
    logic [CLIP_W-1:0]       clip_inc;
    logic                    is_step;
    logic [PH_W-1:0]         phase_inc;
    logic [IDX_W-1:0]        idx_inc;
    logic signed [ACC_W-1:0] acc_upd;
    logic [POWER_W-1:0]      pwr_upd;
    logic [CLIP_W-1:0]       clip_upd;

    assign b_ready  = !b_valid_reg || pix_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign a_fire   = a_valid_reg && b_ready;
    assign in_stall = !a_ready;

    assign pix_valid = b_valid_reg;
    assign pix       = b_rec_reg;

    // phase step, unwrapped around the bias
    assign angle   = angle_of(a_byte_reg);
    assign raw     = angle - prev_reg - unwrap_bias[ANGLE_W-1:0];
    assign dstep   = (BIAS_W+1)'($signed(raw)) + (BIAS_W+1)'(unwrap_bias);
    assign acc_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(dstep);

    always_comb
    begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // sample power and clip detection
    assign i_ext   = 8'($signed(a_byte_reg[7:4]));
    assign q_ext   = 8'($signed(a_byte_reg[3:0]));
    assign isq     = i_ext * i_ext;
    assign qsq     = q_ext * q_ext;
    assign sq_sum  = $unsigned(isq) + $unsigned(qsq);
    assign pwr_sum = {1'b0, pwr_reg} + (POWER_W+1)'(sq_sum);
    assign pwr_sat = pwr_sum[POWER_W] ? {POWER_W{1'b1}} : pwr_sum[POWER_W-1:0];

    assign clip_hit = (a_byte_reg[7:4] == 4'h7) || (a_byte_reg[7:4] == 4'h8) ||
                      (a_byte_reg[3:0] == 4'h7) || (a_byte_reg[3:0] == 4'h8);
    assign clip_inc = (clip_hit && clip_reg != {CLIP_W{1'b1}}) ?
                      CLIP_W'(clip_reg + 1'b1) : clip_reg;

    assign is_step   = (stepc_reg == STEP_LAST);
    assign phase_inc = PH_W'(phase_reg + 1'b1);
    assign idx_inc   = IDX_W'(idx_reg + 1'b1);
    assign acc_upd   = is_step ? acc_sat  : acc_reg;
    assign pwr_upd   = is_step ? pwr_sat  : pwr_reg;
    assign clip_upd  = is_step ? clip_inc : clip_reg;

    always_comb
    begin
        prev_next   = prev_reg;
        acc_next    = acc_reg;
        phase_next  = phase_reg;
        stepc_next  = stepc_reg;
        idx_next    = idx_reg;
        pwr_next    = pwr_reg;
        clip_next   = clip_reg;
        active_next = active_reg;
        b_load      = 1'b0;
        b_rec_next  = b_rec_reg;

        if (a_fire)
        begin
            if (a_start_reg)
            begin
                // restart the row; any partial pixel is dropped
                prev_next   = angle;
                acc_next    = '0;
                phase_next  = '0;
                stepc_next  = '0;
                idx_next    = '0;
                pwr_next    = '0;
                clip_next   = '0;
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                acc_next   = acc_upd;
                pwr_next   = pwr_upd;
                clip_next  = clip_upd;
                phase_next = phase_inc;
                stepc_next = is_step ? '0 : SC_W'(stepc_reg + 1'b1);
                if (is_step)
                begin
                    prev_next = angle;
                end
                if (phase_inc == SPAN_C)
                begin
                    b_load           = 1'b1;
                    b_rec_next.acc   = acc_upd;
                    b_rec_next.power = pwr_upd;
                    b_rec_next.clip  = clip_upd;
                    b_rec_next.last  = (idx_inc == ROW_LEN);
                    idx_next         = idx_inc;
                    if (idx_inc == ROW_LEN)
                    begin
                        active_next = 1'b0;
                    end
                    acc_next   = '0;
                    pwr_next   = '0;
                    clip_next  = '0;
                    phase_next = '0;
                    stepc_next = '0;
                end
            end
        end
    end

    assign b_valid_next = b_load || (b_valid_reg && !pix_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            prev_reg    <= '0;
            acc_reg     <= '0;
            phase_reg   <= '0;
            stepc_reg   <= '0;
            idx_reg     <= '0;
            pwr_reg     <= '0;
            clip_reg    <= '0;
            active_reg  <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            b_valid_reg <= b_valid_next;
            prev_reg    <= prev_next;
            acc_reg     <= acc_next;
            phase_reg   <= phase_next;
            stepc_reg   <= stepc_next;
            idx_reg     <= idx_next;
            pwr_reg     <= pwr_next;
            clip_reg    <= clip_next;
            active_reg  <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_byte_reg  <= sample_byte;
            a_start_reg <= line_start;
        end
        if (b_load)
        begin
            b_rec_reg <= b_rec_next;
        end
    end

    a_start_restarts_row: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && a_start_reg) |=>
            (active_reg && idx_reg == '0 && phase_reg == '0 && acc_reg == '0))
        else $error("line start did not restart the row");

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (b_load && b_rec_next.last) |=> !active_reg)
        else $error("row still active after its final pixel");

    a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (phase_reg == '0 && stepc_reg == '0))
        else $error("sample counters running while row idle");

endmodule

>>> hdl/fmpsd_scale.sv
// ============================================================================
// fmpsd_scale
// Blank-level removal, gain multiply, shift and saturation of each pixel
// record, ending in the output register.
// ============================================================================
module fmpsd_scale #(
    parameter int SAMPLES_PER_PIXEL = fmpsd_pkg::DEF_SAMPLES_PER_PIXEL
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic signed [fmpsd_pkg::BLANK_W-1:0]    blank_level_q8,
    input  logic [fmpsd_pkg::GAIN_W-1:0]            pixel_gain,
    input  logic                                    pix_valid,
    input  fmpsd_pkg::pixel_rec_t                   pix,
    output logic                                    pix_ready,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [fmpsd_pkg::PIX_W-1:0]             pixel_value,
    output logic [fmpsd_pkg::POWER_W-1:0]           power_sum,
    output logic [fmpsd_pkg::CLIP_W-1:0]            clip_count,
    output logic                                    row_last
);
    import fmpsd_pkg::*;

    localparam int SPP_W  = $clog2(SAMPLES_PER_PIXEL + 1);
    localparam int BT_W   = BLANK_W + SPP_W;
    localparam int SH_W   = ACC_W + ACC_SHIFT;
    localparam int NUM_W  = ((SH_W > BT_W) ? SH_W : BT_W) + 1;
    localparam int PROD_W = NUM_W + GAIN_W + 1;

    localparam logic signed [BT_W-1:0] SPP_S = BT_W'(SAMPLES_PER_PIXEL);

    logic signed [BT_W-1:0]  blank_ext;
    logic signed [BT_W-1:0]  blank_term_reg;
    logic signed [NUM_W-1:0] acc_ext;
    logic signed [NUM_W-1:0] num_next;

    logic                    c_valid_reg;
    logic signed [NUM_W-1:0] c_num_reg;
    logic [POWER_W-1:0]      c_power_reg;
    logic [CLIP_W-1:0]       c_clip_reg;
    logic                    c_last_reg;

    logic                     d_ready;
    logic                     c_fire;
    logic signed [PROD_W-1:0] prod;
    logic [PIX_W-1:0]         pix_sat;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   pixel_value_reg;
    logic [POWER_W-1:0] power_sum_reg;
    logic [CLIP_W-1:0]  clip_count_reg;
    logic               row_last_reg;

    assign d_ready   = !out_valid_reg || !out_stall;
    assign pix_ready = !c_valid_reg || d_ready;
    assign c_fire    = c_valid_reg && d_ready;

    // blank contribution of a whole pixel, refreshed every cycle
    assign blank_ext = BT_W'(blank_level_q8);

    assign acc_ext  = NUM_W'($signed(pix.acc));
    assign num_next = (acc_ext <<< ACC_SHIFT) - NUM_W'(blank_term_reg);

    assign prod = $signed(c_num_reg) * $signed({1'b0, pixel_gain});

    always_comb
    begin
        if (prod[PROD_W-1])
        begin
            pix_sat = '0;
        end
        else if (|prod[PROD_W-2:FRAC_SHIFT+PIX_W])
        begin
            pix_sat = {PIX_W{1'b1}};
        end
        else
        begin
            pix_sat = prod[FRAC_SHIFT+PIX_W-1:FRAC_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_ready)
            begin
                c_valid_reg <= pix_valid;
            end
            if (d_ready)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blank_term_reg <= blank_ext * SPP_S;
        if (pix_ready && pix_valid)
        begin
            c_num_reg   <= num_next;
            c_power_reg <= pix.power;
            c_clip_reg  <= pix.clip;
            c_last_reg  <= pix.last;
        end
        if (c_fire)
        begin
            pixel_value_reg <= pix_sat;
            power_sum_reg   <= c_power_reg;
            clip_count_reg  <= c_clip_reg;
            row_last_reg    <= c_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_value_reg;
    assign power_sum   = power_sum_reg;
    assign clip_count  = clip_count_reg;
    assign row_last    = row_last_reg;

    a_record_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready) |=> c_valid_reg)
        else $error("pixel record lost entering scale stage");

    a_record_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        c_fire |=> out_valid_reg)
        else $error("scaled pixel lost before output register");

    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !c_valid_reg) |=> !out_valid_reg)
        else $error("taken pixel shown twice");

endmodule
